// File: design/lfu_pkg.sv
// Package for the LFU cache: sizes, payload structs, cell control types.
package lfu_pkg;

    localparam int Entries   = 16;
    localparam int CountBits = 16;
    localparam int IdxBits   = (Entries > 1) ? $clog2(Entries) : 1;
    localparam int OccBits   = $clog2(Entries + 1);
    localparam int CapBits   = 5;

    localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

    typedef enum logic {
        FUNC_GET = 1'b0,
        FUNC_PUT = 1'b1
    } t_func;

    typedef struct packed {
        logic        func;
        logic [31:0] key;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] data;
        logic        evicted;
        logic [31:0] evicted_key;
    } t_rsp;

    // Candidate handed down the victim-search chain.
    typedef struct packed {
        logic                 found;
        logic [IdxBits-1:0]   idx;
        logic [CountBits-1:0] count;
        logic [IdxBits-1:0]   rank;
        logic [31:0]          key;
    } t_cand;

    // Per-step command broadcast to every cell.
    typedef struct packed {
        logic               touch;     // raise count, move to MRU
        logic               drop;      // remove entry, close rank gap
        logic               fill;      // write new entry into target cell
        logic               wr_value;  // overwrite value (put hit)
        logic [IdxBits-1:0] target;
        logic [IdxBits-1:0] rank;      // old rank of target entry
        logic [IdxBits-1:0] new_rank;  // rank written into target
        logic [31:0]        key;
        logic [31:0]        value;
    } t_cmd;

endpackage

// File: design/lfu_cell.sv
// One cache entry: key, value, use count and recency rank, plus its chain stage.
module lfu_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [lfu_pkg::IdxBits-1:0]      i_id,
    input  lfu_pkg::t_cmd                    i_cmd,
    input  logic [31:0]                      i_lookup_key,
    input  lfu_pkg::t_cand                   i_cand,
    output lfu_pkg::t_cand                   o_cand,
    output logic                             o_valid,
    output logic                             o_match,
    output logic [31:0]                      o_value,
    output logic [lfu_pkg::IdxBits-1:0]      o_rank
);

    logic                             r_valid;
    logic [31:0]                      r_key;
    logic [31:0]                      r_value;
    logic [lfu_pkg::CountBits-1:0]    r_count;
    logic [lfu_pkg::IdxBits-1:0]      r_rank;
    logic                             sel;
    logic                             better;

    assign sel     = (i_cmd.target == i_id);
    assign o_valid = r_valid;
    assign o_match = r_valid && (r_key == i_lookup_key);
    assign o_value = r_value;
    assign o_rank  = r_rank;

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (sel && i_cmd.fill) begin
            r_valid <= 1'b1;
        end else if (sel && i_cmd.drop) begin
            r_valid <= 1'b0;
        end
    end

    // entry payload and rank upkeep
    always_ff @(posedge i_clk) begin
        if (sel && i_cmd.fill) begin
            r_key   <= i_cmd.key;
            r_value <= i_cmd.value;
            r_count <= {{(lfu_pkg::CountBits-1){1'b0}}, 1'b1};
            r_rank  <= i_cmd.new_rank;
        end else if (sel && i_cmd.touch) begin
            if (i_cmd.wr_value) begin
                r_value <= i_cmd.value;
            end
            if (r_count != lfu_pkg::CountMax) begin
                r_count <= r_count + 1'b1;
            end
            r_rank <= i_cmd.new_rank;
        end else if (r_valid && !sel && (i_cmd.touch || i_cmd.drop)
                     && (r_rank > i_cmd.rank)) begin
            r_rank <= r_rank - 1'b1;
        end
    end

    // chain stage: keep the better of incoming candidate and this entry
    assign better = r_valid && (!i_cand.found || (r_count < i_cand.count) ||
                    ((r_count == i_cand.count) && (r_rank < i_cand.rank)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_cand.found <= 1'b0;
        end else begin
            o_cand.found <= i_cand.found || r_valid;
        end
        if (better) begin
            o_cand.idx   <= i_id;
            o_cand.count <= r_count;
            o_cand.rank  <= r_rank;
            o_cand.key   <= r_key;
        end else begin
            o_cand.idx   <= i_cand.idx;
            o_cand.count <= i_cand.count;
            o_cand.rank  <= i_cand.rank;
            o_cand.key   <= i_cand.key;
        end
    end

endmodule

// File: design/lfu_cache_lru_tiebreak.sv
// Top level of the LFU cache with LRU tie break: sequencer and cell chain.
//
// Each get or put passes from acceptance to result through a parallel
// key match (S_MATCH), a pass of the victim candidate down the cell
// chain (S_SCAN; each cell registers the better of its own entry and
// the candidate), and an update (S_DONE). A new request is taken in
// the cycle after the update, so requests do not overlap in the chain.
// The result sits in an output register, so the next request is taken
// while it waits; that request holds in its update cycle until the
// previous result has left. The capacity register may be written at any
// time the block is idle.
module lfu_cache_lru_tiebreak (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  lfu_pkg::t_req                  i_req,
    output logic                           o_valid,
    input  logic                           i_ready,
    output lfu_pkg::t_rsp                  o_rsp,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lfu_pkg::CapBits-1:0]    i_cfg_data
);

    localparam int N  = lfu_pkg::Entries;
    localparam int IB = lfu_pkg::IdxBits;
    localparam int OB = lfu_pkg::OccBits;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MATCH = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    lfu_pkg::t_req               r_req;
    logic [lfu_pkg::CapBits-1:0] r_cap;
    logic [OB-1:0]               r_occ, n_occ;
    logic [IB:0]                 r_cnt;
    logic                        r_hit;
    logic [IB-1:0]               r_hit_idx;
    logic [31:0]                 r_hit_val;
    logic [IB-1:0]               r_hit_rank;
    logic                        r_out_valid;
    lfu_pkg::t_rsp               r_rsp;

    lfu_pkg::t_cand              cand [N+1];
    lfu_pkg::t_cmd               cmd;
    logic [N-1:0]                valid_v, match_v;
    logic [31:0]                 value_a [N];
    logic [IB-1:0]               rank_a [N];
    logic                        any_match;
    logic [IB-1:0]               match_idx;
    logic                        has_free;
    logic [IB-1:0]               free_idx;
    logic [OB-1:0]               eff_cap;
    logic                        accept;
    logic                        done_go;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;
    assign o_valid     = r_out_valid;
    assign o_rsp       = r_rsp;

    // update cycle fires once the output register is free
    assign done_go = (r_state == S_DONE) && (!r_out_valid || i_ready);

    assign cand[0] = '0;

    // row of entry cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        lfu_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_id         (IB'(g)),
            .i_cmd        (cmd),
            .i_lookup_key (r_req.key),
            .i_cand       (cand[g]),
            .o_cand       (cand[g+1]),
            .o_valid      (valid_v[g]),
            .o_match      (match_v[g]),
            .o_value      (value_a[g]),
            .o_rank       (rank_a[g])
        );
    end

    // priority encode match and first free slot
    always_comb begin
        any_match = 1'b0;
        match_idx = '0;
        has_free  = 1'b0;
        free_idx  = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (match_v[i]) begin
                any_match = 1'b1;
                match_idx = IB'(i);
            end
            if (!valid_v[i]) begin
                has_free = 1'b1;
                free_idx = IB'(i);
            end
        end
    end

    assign eff_cap = (r_cap > lfu_pkg::CapBits'(N)) ? OB'(N) : OB'(r_cap);

    // hit entry index, value and old rank, captured with the match
    always_ff @(posedge i_clk) begin
        if (r_state == S_MATCH) begin
            r_hit      <= any_match;
            r_hit_idx  <= match_idx;
            r_hit_val  <= value_a[match_idx];
            r_hit_rank <= rank_a[match_idx];
        end
    end

    // command to the cells in the update cycle
    always_comb begin
        cmd          = '0;
        cmd.key      = r_req.key;
        cmd.value    = r_req.value;
        n_occ        = r_occ;
        if (done_go) begin
            if (r_hit && (r_req.func == lfu_pkg::FUNC_GET || eff_cap != '0)) begin
                cmd.touch    = 1'b1;
                cmd.wr_value = (r_req.func == lfu_pkg::FUNC_PUT);
                cmd.target   = r_hit_idx;
                cmd.rank     = r_hit_rank;
                cmd.new_rank = IB'(r_occ - 1'b1);
            end else if (!r_hit && r_req.func == lfu_pkg::FUNC_PUT && eff_cap != '0) begin
                if (r_occ >= eff_cap && cand[N].found) begin
                    cmd.drop = 1'b1;
                    cmd.target = cand[N].idx;
                    cmd.rank   = cand[N].rank;
                    // refill the freed slot in the same cycle
                    cmd.fill     = 1'b1;
                    cmd.new_rank = IB'(r_occ - 1'b1);
                end else if (has_free) begin
                    cmd.fill     = 1'b1;
                    cmd.target   = free_idx;
                    cmd.new_rank = IB'(r_occ);
                    n_occ        = r_occ + 1'b1;
                end
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_MATCH;
            S_MATCH: n_state = S_SCAN;
            S_SCAN:  if (r_cnt == (IB+1)'(N - 1)) n_state = S_DONE;
            S_DONE:  if (done_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= lfu_pkg::CapBits'(16);
            r_occ       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            r_cnt <= (r_state == S_SCAN) ? r_cnt + 1'b1 : '0;
            if (done_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (done_go) begin
            r_rsp.hit  <= r_hit && (r_req.func == lfu_pkg::FUNC_GET || eff_cap != '0);
            r_rsp.data <= (r_hit && r_req.func == lfu_pkg::FUNC_GET) ? r_hit_val : '0;
            r_rsp.evicted     <= cmd.drop;
            r_rsp.evicted_key <= cmd.drop ? cand[N].key : '0;
        end
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OB'(N)) else $error("occupancy beyond size");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_done_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_go |=> o_valid) else $error("result missing");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_rsp)))
        else $error("result changed while waiting");
`endif

endmodule
